// ===== hw/rtl/vgmp_pkg.sv =====
// types, command codes and helpers shared by the command stream parser
// no dependencies

package vgmp_pkg;

    localparam int SAMPLE_ADDR_WIDTH = 24;
    localparam int FIFO_DEPTH        = 4;
    localparam int FIFO_PTR_W        = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W        = $clog2(FIFO_DEPTH + 1);

    localparam logic [7:0] CMD_TONE_PAIR  = 8'h4F;
    localparam logic [7:0] CMD_TONE       = 8'h50;
    localparam logic [7:0] CMD_FM_PORT0   = 8'h52;
    localparam logic [7:0] CMD_FM_PORT1   = 8'h53;
    localparam logic [7:0] CMD_WAIT_N     = 8'h61;
    localparam logic [7:0] CMD_WAIT_NTSC  = 8'h62;
    localparam logic [7:0] CMD_WAIT_PAL   = 8'h63;
    localparam logic [7:0] CMD_LOOP       = 8'h66;
    localparam logic [7:0] CMD_DATA_BLOCK = 8'h67;
    localparam logic [7:0] CMD_DAC_SEEK   = 8'hE0;

    localparam logic [15:0] WAIT_NTSC_SAMPLES = 16'd735;
    localparam logic [15:0] WAIT_PAL_SAMPLES  = 16'd882;
    localparam logic [7:0]  DAC_REG_ADDR      = 8'h2A;
    localparam logic [7:0]  TONE_PAIR_FIRST   = 8'h06;
    localparam logic [15:0] LOOP_COUNT_MAX    = 16'hFFFF;
    localparam logic [15:0] MAX_LOOPS_RESET   = 16'd2;

    typedef logic [SAMPLE_ADDR_WIDTH-1:0] t_dac_addr;

    typedef enum logic [2:0] {
        EV_TONE    = 3'd0,
        EV_FM      = 3'd1,
        EV_DAC     = 3'd2,
        EV_WAIT    = 3'd3,
        EV_LOOP    = 3'd4,
        EV_UNKNOWN = 3'd5
    } t_event_kind;

    typedef struct packed {
        t_event_kind  event_kind;
        logic         fm_port;
        logic [7:0]   register_address;
        logic [7:0]   write_value;
        logic [15:0]  wait_samples;
        logic [23:0]  sample_address;
        logic [15:0]  loops_seen;
        logic         loops_reached;
        logic         last_of_run;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_decode_out;

    function automatic logic [2:0] operand_count(input logic [7:0] cmd);
        logic [2:0] n;
        case (cmd)
            CMD_TONE_PAIR, CMD_TONE:              n = 3'd1;
            CMD_FM_PORT0, CMD_FM_PORT1, CMD_WAIT_N: n = 3'd2;
            CMD_DAC_SEEK:                         n = 3'd4;
            default:                              n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

// ===== hw/rtl/vgmp_command_stream_parser_top.sv =====
// top level of the sound-chip command stream parser
// uses vgmp_pkg, vgmp_decoder and vgmp_result_fifo
//
// the slave stream takes one command stream byte per beat in s_axis_tdata
// the master stream gives one event per beat: event kind in m_axis_tuser,
// tlast marks the final event caused by one input byte
// commands with operands give their events when the last operand byte arrives;
// tone pair commands give two events, 0xE0 and 0x67 give none
// an event is written into the result queue before it appears on the master side
// throughput: one byte per cycle while the queue has room, set by the single pass
// decoder; events leave at one per cycle from a four entry result queue
// when the receiver stalls the queue fills and s_axis_tready drops once fewer
// than two entries are free; no byte or event is dropped
// max_loops is written through i_cfg_wr_en / i_cfg_wr_data, reset value 2
// synchronous active-low reset clears parse state, dac position, loop count
// and the queue

module vgm_command_stream_parser_top
    import vgmp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [15:0] i_cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // stream_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // fm_port, register_address, write_value, wait_samples, sample_address,
    // loops_seen, loops_reached, zero pad
    output logic [79:0] m_axis_tdata,
    output logic [2:0]  m_axis_tuser,   // event_kind
    output logic        m_axis_tlast    // last_of_run
);

    logic [15:0] r_max_loops;
    logic        accept;
    logic        room;
    t_decode_out decode;
    t_result     head;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_loops <= MAX_LOOPS_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_loops <= i_cfg_wr_data;
        end
    end

    assign s_axis_tready = room;
    assign accept        = s_axis_tvalid && room;

    vgmp_decoder u_decoder (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (s_axis_tdata),
        .i_max_loops (r_max_loops),
        .o_decode    (decode)
    );

    vgmp_result_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_count (decode.count),
        .i_first      (decode.first),
        .i_second     (decode.second),
        .i_pop        (m_axis_tready),
        .o_room       (room),
        .o_valid      (m_axis_tvalid),
        .o_head       (head)
    );

    assign m_axis_tuser = head.event_kind;
    assign m_axis_tlast = head.last_of_run;
    assign m_axis_tdata = {6'b0, head.loops_reached, head.loops_seen,
                           head.sample_address, head.wait_samples,
                           head.write_value, head.register_address, head.fm_port};

endmodule

// ===== hw/rtl/vgmp_decoder.sv =====
// command decoder: parse phase, operand gather, dac position and loop counter
// builds up to two result records per accepted byte; uses vgmp_pkg

module vgmp_decoder
    import vgmp_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_accept,
    input  logic [7:0]  i_byte,
    input  logic [15:0] i_max_loops,
    output t_decode_out o_decode
);

    logic [2:0]  r_phase, n_phase;
    logic [7:0]  r_cmd, n_cmd;
    logic [31:0] r_gather, n_gather;
    t_dac_addr   r_dac, n_dac;
    logic [15:0] r_loops, n_loops;

    logic [2:0]  total;
    logic [1:0]  idx;
    logic [31:0] gather_full;
    logic [2:0]  need;
    t_result     blank, res0, res1;
    logic [1:0]  cnt;

    always_comb begin
        n_phase  = r_phase;
        n_cmd    = r_cmd;
        n_gather = r_gather;
        n_dac    = r_dac;
        n_loops  = r_loops;
        blank    = '0;
        res0     = '0;
        res1     = '0;
        cnt      = 2'd0;

        total       = operand_count(r_cmd);
        idx         = 2'(total - r_phase);
        gather_full = r_gather | (32'(i_byte) << {idx, 3'b000});
        need        = operand_count(i_byte);

        if (r_phase == 3'd0) begin
            if (need != 3'd0) begin
                n_cmd    = i_byte;
                n_gather = '0;
                n_phase  = need;
            end else if (i_byte == CMD_WAIT_NTSC) begin
                res0.event_kind   = EV_WAIT;
                res0.wait_samples = WAIT_NTSC_SAMPLES;
                cnt = 2'd1;
            end else if (i_byte == CMD_WAIT_PAL) begin
                res0.event_kind   = EV_WAIT;
                res0.wait_samples = WAIT_PAL_SAMPLES;
                cnt = 2'd1;
            end else if (i_byte == CMD_DATA_BLOCK) begin
                cnt = 2'd0;
            end else if (i_byte inside {[8'h70:8'h7F]}) begin
                res0.event_kind   = EV_WAIT;
                res0.wait_samples = 16'(i_byte[3:0]) + 16'd1;
                cnt = 2'd1;
            end else if (i_byte inside {[8'h80:8'h8F]}) begin
                res0.event_kind       = EV_DAC;
                res0.register_address = DAC_REG_ADDR;
                res0.wait_samples     = 16'(i_byte[3:0]);
                res0.sample_address   = 24'(r_dac);
                n_dac = r_dac + t_dac_addr'(1);
                cnt = 2'd1;
            end else if (i_byte == CMD_LOOP) begin
                if (r_loops != LOOP_COUNT_MAX) begin
                    n_loops = r_loops + 16'd1;
                end
                res0.event_kind = EV_LOOP;
                cnt = 2'd1;
            end else begin
                res0.event_kind  = EV_UNKNOWN;
                res0.write_value = i_byte;
                cnt = 2'd1;
            end
        end else begin
            n_phase  = r_phase - 3'd1;
            n_gather = gather_full;
            if (r_phase == 3'd1) begin
                case (r_cmd)
                    CMD_TONE_PAIR: begin
                        res0.event_kind  = EV_TONE;
                        res0.write_value = TONE_PAIR_FIRST;
                        res1.event_kind  = EV_TONE;
                        res1.write_value = gather_full[7:0];
                        cnt = 2'd2;
                    end
                    CMD_TONE: begin
                        res0.event_kind  = EV_TONE;
                        res0.write_value = gather_full[7:0];
                        cnt = 2'd1;
                    end
                    CMD_FM_PORT0, CMD_FM_PORT1: begin
                        res0.event_kind       = EV_FM;
                        res0.fm_port          = r_cmd[0];
                        res0.register_address = gather_full[7:0];
                        res0.write_value      = gather_full[15:8];
                        cnt = 2'd1;
                    end
                    CMD_WAIT_N: begin
                        res0.event_kind   = EV_WAIT;
                        res0.wait_samples = gather_full[15:0];
                        cnt = 2'd1;
                    end
                    default: begin
                        n_dac = t_dac_addr'(gather_full);
                    end
                endcase
            end
        end

        res0.loops_seen    = n_loops;
        res0.loops_reached = (n_loops == i_max_loops);
        res0.last_of_run   = (cnt == 2'd1);
        res1.loops_seen    = n_loops;
        res1.loops_reached = (n_loops == i_max_loops);
        res1.last_of_run   = 1'b1;

        o_decode.count  = i_accept ? cnt : 2'd0;
        o_decode.first  = (cnt != 2'd0) ? res0 : blank;
        o_decode.second = (cnt == 2'd2) ? res1 : blank;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= '0;
            r_cmd    <= '0;
            r_gather <= '0;
            r_dac    <= '0;
            r_loops  <= '0;
        end else if (i_accept) begin
            r_phase  <= n_phase;
            r_cmd    <= n_cmd;
            r_gather <= n_gather;
            r_dac    <= n_dac;
            r_loops  <= n_loops;
        end
    end

    a_phase_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase <= 3'd4)
        else $error("parse phase out of range");

    a_gather_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != 3'd0) |-> (operand_count(r_cmd) >= r_phase))
        else $error("operand gather without a matching command");

endmodule

// ===== hw/rtl/vgmp_result_fifo.sv =====
// small result queue taking up to two records per cycle, one out per beat
// uses vgmp_pkg

module vgmp_result_fifo
    import vgmp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic [1:0] i_push_count,
    input  t_result i_first,
    input  t_result i_second,
    input  logic    i_pop,
    output logic    o_room,
    output logic    o_valid,
    output t_result o_head
);

    t_result               r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_head, n_head;
    logic [FIFO_PTR_W-1:0] r_tail, n_tail;
    logic [FIFO_CNT_W-1:0] r_count, n_count;
    logic                  pop;
    logic [FIFO_PTR_W-1:0] tail_next;

    assign o_valid   = (r_count != '0);
    assign o_room    = (r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2));
    assign o_head    = r_mem[r_head];
    assign pop       = i_pop && o_valid;
    assign tail_next = r_tail + FIFO_PTR_W'(1);

    always_comb begin
        n_head  = pop ? r_head + FIFO_PTR_W'(1) : r_head;
        n_tail  = r_tail + FIFO_PTR_W'(i_push_count);
        n_count = r_count + FIFO_CNT_W'(i_push_count) - FIFO_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push_count != 2'd0) begin
            r_mem[r_tail] <= i_first;
        end
        if (i_push_count == 2'd2) begin
            r_mem[tail_next] <= i_second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_count != 2'd0) |-> (r_count <= FIFO_CNT_W'(FIFO_DEPTH - 2)))
        else $error("result queue overflow");

    a_count_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push_count == 2'd0 && !pop) |=> $stable(r_count))
        else $error("queue count moved without push or pop");

endmodule
